// File: sv/rssc_pkg.sv
`default_nettype none
package rssc_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned FracShift   = 16;
  localparam int unsigned DivSteps    = 2;
  localparam int unsigned DivStages   = 32 / DivSteps;

  typedef enum logic [2:0] {
    REG_MAPPING_MODE  = 3'd0,
    REG_CROP_ORIGIN   = 3'd1,
    REG_CROP_WIDTH    = 3'd2,
    REG_CROP_HEIGHT   = 3'd3,
    REG_OUT_WIDTH     = 3'd4,
    REG_OUT_HEIGHT    = 3'd5,
    REG_SOURCE_WIDTH  = 3'd6,
    REG_SOURCE_HEIGHT = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] nq;
  } div_t;

  // one restoring step: shift a dividend bit in, a quotient bit out
  function automatic div_t div_step(div_t a, logic [15:0] d);
    logic [16:0] t;
    div_t r;
    t = {a.rem, a.nq[31]};
    if (t >= {1'b0, d}) begin
      r.rem = 16'(t - {1'b0, d});
      r.nq  = {a.nq[30:0], 1'b1};
    end else begin
      r.rem = t[15:0];
      r.nq  = {a.nq[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/rotate_scale_source_coordinate_top.sv
// each word passes the divider stages, then the product, mirror and corner registers
// one word per cycle unless stalled; the two 16-stage radix-4 dividers set the depth
// a stalled output holds the whole pipeline, nothing is lost or repeated
// reset clears the valid bits and loads the register reset values
// configuration writes are taken in every cycle
`default_nettype none
module rotate_scale_source_coordinate_top #(
  parameter int unsigned COORD_BITS = rssc_pkg::CoordBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // col_index, row_counter
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // corner0_x, corner0_y, corner1_x, corner1_y
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned NS = rssc_pkg::DivStages;
  localparam logic [15:0] MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

  logic [2:0]  mapping_mode;
  logic [31:0] crop_origin;
  logic [15:0] crop_width, crop_height, out_width, out_height;
  logic [15:0] source_width, source_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_mode  <= '0;
      crop_origin   <= '0;
      crop_width    <= 16'd1;
      crop_height   <= 16'd1;
      out_width     <= 16'd1;
      out_height    <= 16'd1;
      source_width  <= 16'd1;
      source_height <= 16'd1;
    end else if (cfg_valid) begin
      unique case (rssc_pkg::reg_index_t'(cfg_index))
        rssc_pkg::REG_MAPPING_MODE:  mapping_mode  <= cfg_data[2:0];
        rssc_pkg::REG_CROP_ORIGIN:   crop_origin   <= cfg_data;
        rssc_pkg::REG_CROP_WIDTH:    crop_width    <= cfg_data[15:0];
        rssc_pkg::REG_CROP_HEIGHT:   crop_height   <= cfg_data[15:0];
        rssc_pkg::REG_OUT_WIDTH:     out_width     <= cfg_data[15:0];
        rssc_pkg::REG_OUT_HEIGHT:    out_height    <= cfg_data[15:0];
        rssc_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[15:0];
        rssc_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [1:0] rot;
  logic       resample, x_j, mir_x, mir_y, dec_x, dec_y;
  logic [15:0] dw, dh;
  logic [31:0] ox, oy, cw1, ch1;

  assign rot      = mapping_mode[1:0];
  assign resample = mapping_mode[2];
  assign x_j      = ~rot[0];
  assign mir_x    = resample ? rot[1] : (rot[1] ^ rot[0]);
  assign mir_y    = resample ? (rot[1] ^ rot[0]) : ~rot[1];
  assign dec_x    = rot[1];
  assign dec_y    = rot[1] ^ rot[0];
  assign dw       = (out_width == 16'd0) ? 16'd1 : out_width;
  assign dh       = (out_height == 16'd0) ? 16'd1 : out_height;
  assign ox       = {crop_origin[15:0], 16'h0};
  assign oy       = {crop_origin[31:16], 16'h0};
  assign cw1      = 32'(crop_width) - 32'd1;
  assign ch1      = 32'(crop_height) - 32'd1;

  logic en;
  logic [NS+2:0] vld;
  assign en       = ~vld[NS+2] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NS+2];

  rssc_pkg::div_t dj [NS];
  rssc_pkg::div_t di [NS];
  rssc_pkg::div_t dj_next [NS];
  rssc_pkg::div_t di_next [NS];

  always_comb begin
    rssc_pkg::div_t aj, ai;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        aj = '{rem: 16'h0, nq: {s_tdata[15:0] & MASK, 16'h0}};
        ai = '{rem: 16'h0, nq: {s_tdata[31:16] & MASK, 16'h0}};
      end else begin
        aj = dj[(k == 0) ? 0 : k - 1];
        ai = di[(k == 0) ? 0 : k - 1];
      end
      for (int s = 0; s < rssc_pkg::DivSteps; s++) begin
        aj = rssc_pkg::div_step(aj, dw);
        ai = rssc_pkg::div_step(ai, dh);
      end
      dj_next[k] = aj;
      di_next[k] = ai;
    end
  end

  logic [31:0] px, py, lx, ly;
  logic [15:0] x0, y0, x1, y1, x0c, y0c;

  assign x0c = lx[31:16] & MASK;
  assign y0c = ly[31:16] & MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS+1:0], s_tvalid};
    end
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        dj[k] <= dj_next[k];
        di[k] <= di_next[k];
      end
      px <= 32'((x_j ? dj[NS-1].nq : di[NS-1].nq) * cw1);
      py <= 32'((x_j ? di[NS-1].nq : dj[NS-1].nq) * ch1);
      lx <= mir_x ? ({crop_width, 16'h0} - (px + ox) - 32'd1) : (px + ox);
      ly <= mir_y ? ({crop_height, 16'h0} - (py + oy) - 32'd1) : (py + oy);
      x0 <= x0c;
      y0 <= y0c;
      x1 <= x0c;
      y1 <= y0c;
      if (resample) begin
        if (dec_x) begin
          if (lx[15:0] != 16'h0) x1 <= 16'(x0c - 16'd1) & MASK;
        end else if ({1'b0, x0c} + 17'd1 < {1'b0, source_width}) begin
          x1 <= 16'(x0c + 16'd1) & MASK;
        end
        if (dec_y) begin
          if (ly[15:0] != 16'h0) y1 <= 16'(y0c - 16'd1) & MASK;
        end else if ({1'b0, y0c} + 17'd1 < {1'b0, source_height}) begin
          y1 <= 16'(y0c + 16'd1) & MASK;
        end
      end
    end
  end

  assign m_tdata = {y1, x1, y0, x0};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled without a waiting output word");
  a_nearest_same: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !mapping_mode[2] |-> (x1 == x0) && (y1 == y0))
    else $error("nearest mode corners differ");
  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[1] == $past(vld[0]))
    else $error("valid bit lost in divider pipeline");

endmodule
`default_nettype wire
